[rtl/tccw_pkg.sv]
// Shared constants and controller/datapath interface types for the text console
// character writer. Used by every module of the block; depends on nothing.
`default_nettype none

package tccw_pkg;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = ROWS * COLS;

  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h40;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic load;      // latch accepted item, start its store read
    logic exec;      // evaluate item, update cursor, write cell
    logic cnt_clr;   // zero the sweep counter
    logic clr_wr;    // clearing pass: write zero at counter
    logic scroll_rd; // scroll: read cell one row below counter
    logic out_load;  // move result into output register
  } tccw_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic cnt_last;
  } tccw_sts_t;

endpackage

`default_nettype wire

[rtl/text_console_char_writer_unit.sv]
// Top level of the text console character writer: controller plus datapath.
// Depends on tccw_pkg, tccw_ctrl and tccw_datapath.
//
// Text-mode console engine with an 80 x 25 store of 16-bit cells (attribute
// high, character low) and a cursor. One transaction is taken at a time. After
// reset the store is cleared one cell a cycle, and in_ready stays low until the
// clear is done (configuration writes are still taken). A read or a put that
// does not scroll presents its result after execute, then output load, which
// waits for the output register to be free; the controller then returns to
// idle for the next item. A put that scrolls also copies the store one cell
// per cycle through its single write port. The next item is accepted while a
// finished result waits in the output register.
`default_nettype none

module text_console_char_writer_unit
  import tccw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CHAR_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              func,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [ADDR_W-1:0] read_addr,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      cursor_pos,
  output logic [COL_W-1:0]       cursor_col,
  output logic [ROW_W-1:0]       cursor_row,
  output logic                   wrote_cell,
  output logic [ADDR_W-1:0]      write_addr,
  output logic [CELL_W-1:0]      write_data,
  output logic                   scrolled,
  output logic [CELL_W-1:0]      read_data
);

  tccw_cmd_t cmd;
  tccw_sts_t sts;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tccw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .func       (func),
    .char_code  (char_code),
    .read_addr  (read_addr),
    .cursor_pos (cursor_pos),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .wrote_cell (wrote_cell),
    .write_addr (write_addr),
    .write_data (write_data),
    .scrolled   (scrolled),
    .read_data  (read_data)
  );

endmodule

`default_nettype wire

[rtl/tccw_ctrl.sv]
// Controller state machine for the text console character writer.
// Depends on tccw_pkg; drives tccw_datapath through tccw_cmd_t.
`default_nettype none

module tccw_ctrl
  import tccw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire tccw_sts_t sts,
  output tccw_cmd_t      cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR      = 6'b000001,
    ST_IDLE       = 6'b000010,
    ST_EXEC       = 6'b000100,
    ST_SCROLL     = 6'b001000,
    ST_SCROLL_END = 6'b010000,
    ST_DONE       = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.cnt_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next  = sts.need_scroll ? ST_SCROLL : ST_DONE;
      end
      ST_SCROLL: begin
        cmd.scroll_rd = 1'b1;
        if (sts.cnt_last) begin
          state_next = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: begin
        // last copy write drains here
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tccw_datapath.sv]
// Datapath of the text console character writer: screen store, cursor,
// attribute register, sweep counter and result registers. Depends on tccw_pkg.
`default_nettype none

module tccw_datapath
  import tccw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tccw_cmd_t         cmd,
  output tccw_sts_t              sts,
  input  wire logic              cfg_we,
  input  wire logic [CHAR_W-1:0] cfg_wdata,
  input  wire logic              func,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [ADDR_W-1:0] read_addr,
  output logic [ADDR_W-1:0]      cursor_pos,
  output logic [COL_W-1:0]       cursor_col,
  output logic [ROW_W-1:0]       cursor_row,
  output logic                   wrote_cell,
  output logic [ADDR_W-1:0]      write_addr,
  output logic [CELL_W-1:0]      write_data,
  output logic                   scrolled,
  output logic [CELL_W-1:0]      read_data
);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic [CHAR_W-1:0] attr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              func_q;
  logic [CHAR_W-1:0] code_q;
  logic [ADDR_W-1:0] raddr_q;

  logic [ADDR_W-1:0] cnt, cnt_d;
  logic              pend;

  // result held until the output register is free
  logic [ADDR_W-1:0] r_pos, r_waddr;
  logic [COL_W-1:0]  r_col;
  logic [ROW_W-1:0]  r_row;
  logic              r_wrote, r_scrolled;
  logic [CELL_W-1:0] r_wdata, r_rdata;

  // step evaluation
  logic [COL_W:0]    col_n;
  logic [ROW_W:0]    row_n;
  logic [COL_W-1:0]  col_f;
  logic [ROW_W-1:0]  row_f;
  logic              put, printable, scroll_n;
  logic [ADDR_W-1:0] cur_addr, pos_n;
  logic [CELL_W-1:0] blank, copy_data;

  assign put       = (func_q == FUNC_PUT);
  assign printable = put && (code_q >= CH_SPACE);
  assign cur_addr  = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
  assign blank     = {attr, CH_SPACE};

  always_comb begin
    col_n = {1'b0, col};
    row_n = {1'b0, row};
    if (put) begin
      if (code_q == CH_BS) begin
        if (col != '0) begin
          col_n = col_n - 1'b1;
        end
      end else if (code_q == CH_TAB) begin
        col_n = (col_n + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_STEP - 1);
      end else if (code_q == CH_CR) begin
        col_n = '0;
      end else if (code_q == CH_LF) begin
        col_n = '0;
        row_n = row_n + 1'b1;
      end else if (printable) begin
        col_n = col_n + 1'b1;
      end
    end
    if (col_n >= (COL_W+1)'(COLS)) begin
      col_n = '0;
      row_n = row_n + 1'b1;
    end
    scroll_n = 1'b0;
    if (row_n >= (ROW_W+1)'(ROWS)) begin
      scroll_n = 1'b1;
      row_n    = (ROW_W+1)'(ROWS - 1);
    end
    col_f = col_n[COL_W-1:0];
    row_f = row_n[ROW_W-1:0];
  end

  assign pos_n = ADDR_W'(row_f) * ADDR_W'(COLS) + ADDR_W'(col_f);

  assign sts.need_scroll = scroll_n;
  assign sts.cnt_last    = (cnt == ADDR_W'(CELLS - 1));

  // store ports: clearing pass, scroll copy, or a put
  assign copy_data = (cnt_d < ADDR_W'(CELLS - COLS)) ? mem_q : blank;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {attr, code_q};
    if (cmd.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cnt;
      mem_wdata = '0;
    end else if (pend) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_d;
      mem_wdata = copy_data;
    end else if (cmd.exec && printable) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = read_addr;
    if (cmd.load) begin
      mem_re = (read_addr < ADDR_W'(CELLS));
    end else if (cmd.scroll_rd) begin
      mem_raddr = cnt + ADDR_W'(COLS);
      mem_re    = (cnt < ADDR_W'(CELLS - COLS));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= ATTR_RESET;
      col  <= '0;
      row  <= '0;
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (cmd.exec) begin
        col <= col_f;
        row <= row_f;
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.clr_wr || cmd.scroll_rd) begin
        cnt <= cnt + 1'b1;
      end
      pend <= cmd.scroll_rd;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt_d <= cnt;
    if (cmd.load) begin
      func_q  <= func;
      code_q  <= char_code;
      raddr_q <= read_addr;
    end
    if (cmd.exec) begin
      r_pos      <= pos_n;
      r_col      <= col_f;
      r_row      <= row_f;
      r_wrote    <= printable;
      r_waddr    <= printable ? cur_addr : '0;
      r_wdata    <= printable ? {attr, code_q} : '0;
      r_scrolled <= scroll_n;
      r_rdata    <= (!put && raddr_q < ADDR_W'(CELLS)) ? mem_q : '0;
    end
    if (cmd.out_load) begin
      cursor_pos <= r_pos;
      cursor_col <= r_col;
      cursor_row <= r_row;
      wrote_cell <= r_wrote;
      write_addr <= r_waddr;
      write_data <= r_wdata;
      scrolled   <= r_scrolled;
      read_data  <= r_rdata;
    end
  end

endmodule

`default_nettype wire
